FILE: rtl/forward_match_priority_queue_dropper_core_defines.svh
// Assertion macros shared by the RTL files.
// Depends on nothing; included by modules that carry checks.
`ifndef FORWARD_MATCH_PRIORITY_QUEUE_DROPPER_CORE_DEFINES_SVH
`define FORWARD_MATCH_PRIORITY_QUEUE_DROPPER_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define FMPQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
// implication whose consequence is checked in the cycle after the antecedent
`define FMPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

FILE: rtl/fmpq_pkg.sv
// Shared constants and types of the forwarding priority queue.
// Depends on nothing.
package fmpq_pkg;
	localparam int TableEntries = 16;
	localparam int QueueDepth = 64;
	localparam int Levels = 3;
	localparam int IdxW = $clog2(TableEntries);
	localparam int PtrW = $clog2(QueueDepth);
	localparam int FillW = $clog2(QueueDepth + 1);
	localparam int QW = 2;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_ARRIVE = 2'd1;
	localparam logic [1:0] OP_SERVICE = 2'd2;

	localparam logic [2:0] KIND_WRITTEN = 3'd0;
	localparam logic [2:0] KIND_QUEUED = 3'd1;
	localparam logic [2:0] KIND_DROPPED = 3'd2;
	localparam logic [2:0] KIND_SENT = 3'd3;
	localparam logic [2:0] KIND_IDLE = 3'd4;

	localparam logic [1:0] WHY_NO_ENTRY = 2'd0;
	localparam logic [1:0] WHY_FULL = 2'd1;
	localparam logic [1:0] WHY_LOSS = 2'd2;
	localparam logic [1:0] WHY_PRIO = 2'd3;

	localparam logic [7:0] TYPE_E = 8'h45;
	localparam logic [7:0] TYPE_R = 8'h52;

	typedef struct packed {
		logic [31:0] next_ip;
		logic [15:0] hop_port;
		logic [15:0] delay_ms;
		logic [6:0] loss;
	} action_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [7:0] ptype;
		action_t act;
	} item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] reason;
		logic [15:0] tag;
		logic [31:0] next_ip;
		logic [15:0] hop_port;
		logic [15:0] delay_ms;
		logic [1:0] queue;
	} result_t;

	// search request and answer between the sequencer and the table
	typedef struct packed {
		logic start;
		logic [47:0] key;
	} srch_req_t;

	typedef struct packed {
		logic done;
		logic hit;
		action_t act;
	} srch_rsp_t;
endpackage

FILE: rtl/fmpq_table.sv
// Forwarding table with a single key comparator walked one slot per cycle.
// Depends on fmpq_pkg.
module fmpq_table import fmpq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [IdxW-1:0] wr_idx,
	input logic [47:0] wr_key,
	input action_t wr_act,
	input srch_req_t req,
	output srch_rsp_t rsp
);
	logic [TableEntries-1:0] valid_q;
	logic [47:0] key_mem [TableEntries];
	action_t act_mem [TableEntries];
	logic busy_q;
	logic [IdxW-1:0] ptr_q;
	logic [47:0] skey_q;
	logic match;
	logic done_q, hit_q;
	action_t act_q;

	assign match = valid_q[ptr_q] && (key_mem[ptr_q] == skey_q);
	assign rsp = {done_q, hit_q, act_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_idx] <= wr_key;
			act_mem[wr_idx] <= wr_act;
		end
		if (req.start) skey_q <= req.key;
		if (busy_q) act_q <= act_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			busy_q <= 1'b0;
			ptr_q <= '0;
			done_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (wr_en) valid_q[wr_idx] <= 1'b1;
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				ptr_q <= '0;
			end else if (busy_q) begin
				if (match || ptr_q == IdxW'(TableEntries - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					hit_q <= match;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

	`include "forward_match_priority_queue_dropper_core_defines.svh"
	`FMPQ_ASSERT_NEXT(a_done_ends_walk, busy_q && match, !busy_q && rsp.done)
	`FMPQ_ASSERT_IMP(a_no_write_in_walk, busy_q, !wr_en)
	`FMPQ_ASSERT_NEXT(a_start_busy, req.start, busy_q)
endmodule

FILE: rtl/fmpq_queues.sv
// Three priority FIFOs sharing one item memory, with fill and head counters.
// Depends on fmpq_pkg.
module fmpq_queues import fmpq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [QW-1:0] push_q,
	input item_t push_item,
	input logic pop,
	input logic [QW-1:0] pop_q,
	output item_t pop_item,
	output logic [FillW-1:0] fill [Levels]
);
	item_t mem_q [Levels*QueueDepth];
	logic [FillW-1:0] fill_q [Levels];
	logic [PtrW-1:0] head_q [Levels];
	logic [PtrW-1:0] tail;
	logic [$clog2(Levels*QueueDepth)-1:0] waddr, raddr;

	assign tail = head_q[push_q] + PtrW'(fill_q[push_q]);
	assign waddr = {push_q, tail};
	assign raddr = {pop_q, head_q[pop_q]};
	assign fill = fill_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[waddr] <= push_item;
		if (pop) pop_item <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Levels; i++) begin
				fill_q[i] <= '0;
				head_q[i] <= '0;
			end
		end else begin
			if (push) fill_q[push_q] <= fill_q[push_q] + 1'b1;
			if (pop) begin
				fill_q[pop_q] <= fill_q[pop_q] - 1'b1;
				head_q[pop_q] <= head_q[pop_q] + 1'b1;
			end
		end
	end

	`include "forward_match_priority_queue_dropper_core_defines.svh"
	`FMPQ_ASSERT_IMP(a_no_overflow, push, fill_q[push_q] != FillW'(QueueDepth))
	`FMPQ_ASSERT_IMP(a_no_underflow, pop, fill_q[pop_q] != '0)
	`FMPQ_ASSERT_IMP(a_one_side, push, !pop)
endmodule

FILE: rtl/forward_match_priority_queue_dropper_core.sv
// Strict-priority forwarding queue with tail drop. One word in gives exactly one result
// word; operation 3 is dropped with no result. A write-entry passes through the evaluate
// state; an arrival waits for the walk of the 16-slot table through a single key
// comparator, one slot per cycle; a service tick passes through the pop and output states
// for the registered FIFO memory read, or stays idle when every queue is empty. tready
// is low while a word is in work, and a waiting result holds off the next word only until
// the receiver takes it. No clearing pass after reset.
// Depends on fmpq_pkg, fmpq_table, fmpq_queues and the defines header.
module forward_match_priority_queue_dropper_core import fmpq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [6:0] cfg_wr_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// entry_index, dest_ip, dst_port, next_ip, hop_port, delay_ms, loss_percent,
	// priority_req, packet_type, packet_tag, loss_draw, zero pad to 168
	input logic [167:0] s_axis_tdata,
	// operation
	input logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// drop_reason, out_tag, out_next_ip, out_hop_port, out_delay_ms, out_queue, pad to 88
	output logic [87:0] m_axis_tdata,
	// result_kind
	output logic [2:0] m_axis_tuser
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRCH = 3'd1;
	localparam logic [2:0] ST_POP = 3'd2;
	localparam logic [2:0] ST_EVAL = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] state_q;
	logic [6:0] limit_q;
	logic [1:0] op_q;
	logic [3:0] idx_q;
	logic [47:0] key_q;
	action_t wact_q;
	logic [7:0] prio_q, ptype_q;
	logic [15:0] tag_q;
	logic [6:0] draw_q;
	logic [QW-1:0] sel_q;
	result_t res_q, res_d;
	logic out_valid_q;
	logic [FillW-1:0] fill [Levels];
	srch_req_t req;
	srch_rsp_t rsp;
	item_t pop_item;
	logic push, pop, in_acc, wr_en;
	logic [QW-1:0] pq;
	logic [FillW-1:0] pf;
	logic room;
	logic res_load;

	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = res_q.kind;
	assign m_axis_tdata = {4'b0, res_q.queue, res_q.delay_ms, res_q.hop_port,
		res_q.next_ip, res_q.tag, res_q.reason};

	assign wr_en = (state_q == ST_EVAL) && (op_q == OP_WRITE);
	assign req = {in_acc && (s_axis_tuser == OP_ARRIVE), s_axis_tdata[51:4]};
	assign pq = QW'(prio_q - 8'd1);
	assign pf = fill[pq];
	assign room = (pf != FillW'(QueueDepth)) &&
		((pf < FillW'(limit_q)) || (ptype_q == TYPE_E));
	assign push = (state_q == ST_SRCH) && rsp.done && rsp.hit &&
		(prio_q >= 8'd1) && (prio_q <= 8'd3) && room;
	assign pop = (state_q == ST_IDLE) && in_acc && (s_axis_tuser == OP_SERVICE) &&
		((fill[0] != '0) || (fill[1] != '0) || (fill[2] != '0));
	assign res_load = (state_q == ST_EVAL) || (state_q == ST_OUT) ||
		((state_q == ST_SRCH) && rsp.done) ||
		(in_acc && (s_axis_tuser == OP_SERVICE) && !pop);

	fmpq_table u_table (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_idx(idx_q[IdxW-1:0]),
		.wr_key(key_q), .wr_act(wact_q), .req(req), .rsp(rsp)
	);

	fmpq_queues u_queues (
		.clk(clk), .arst_n(arst_n), .push(push), .push_q(pq),
		.push_item({tag_q, ptype_q, rsp.act}), .pop(pop),
		.pop_q(fill[0] != '0 ? 2'd0 : (fill[1] != '0 ? 2'd1 : 2'd2)),
		.pop_item(pop_item), .fill(fill)
	);

	always_comb begin
		res_d = '0;
		case (state_q)
			ST_EVAL: res_d.kind = KIND_WRITTEN;
			ST_SRCH: begin
				res_d.tag = tag_q;
				if (!rsp.hit) begin
					res_d.kind = KIND_DROPPED;
					res_d.reason = WHY_NO_ENTRY;
				end else if (prio_q < 8'd1 || prio_q > 8'd3) begin
					res_d.kind = KIND_DROPPED;
					res_d.reason = WHY_PRIO;
				end else if (room) begin
					res_d.kind = KIND_QUEUED;
					res_d.queue = pq;
				end else begin
					res_d.kind = KIND_DROPPED;
					res_d.reason = WHY_FULL;
					res_d.queue = pq;
				end
			end
			ST_OUT: begin
				res_d.tag = pop_item.tag;
				res_d.delay_ms = pop_item.act.delay_ms;
				res_d.queue = sel_q;
				if (pop_item.ptype != TYPE_R && pop_item.ptype != TYPE_E &&
					pop_item.act.loss >= draw_q) begin
					res_d.kind = KIND_DROPPED;
					res_d.reason = WHY_LOSS;
				end else begin
					res_d.kind = KIND_SENT;
					res_d.next_ip = pop_item.act.next_ip;
					res_d.hop_port = pop_item.act.hop_port;
				end
			end
			default: res_d.kind = KIND_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q <= s_axis_tuser;
			idx_q <= s_axis_tdata[3:0];
			key_q <= s_axis_tdata[51:4];
			wact_q <= {s_axis_tdata[83:52], s_axis_tdata[99:84],
				s_axis_tdata[115:100], s_axis_tdata[122:116]};
			prio_q <= s_axis_tdata[130:123];
			ptype_q <= s_axis_tdata[138:131];
			tag_q <= s_axis_tdata[154:139];
			draw_q <= s_axis_tdata[161:155];
			sel_q <= fill[0] != '0 ? 2'd0 : (fill[1] != '0 ? 2'd1 : 2'd2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limit_q <= 7'd64;
			out_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cfg_wr_en) limit_q <= cfg_wr_data;
			if (res_load) res_q <= res_d;
			out_valid_q <= res_load || (out_valid_q && !m_axis_tready);
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (s_axis_tuser)
							OP_WRITE: state_q <= ST_EVAL;
							OP_ARRIVE: state_q <= ST_SRCH;
							OP_SERVICE: begin
								if (pop) state_q <= ST_POP;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SRCH: begin
					if (rsp.done) state_q <= ST_IDLE;
				end
				ST_POP: state_q <= ST_OUT;
				ST_EVAL: state_q <= ST_IDLE;
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "forward_match_priority_queue_dropper_core_defines.svh"
	`FMPQ_ASSERT_IMP(a_busy_not_ready, state_q != ST_IDLE, !s_axis_tready)
	`FMPQ_ASSERT_IMP(a_result_one_state, out_valid_q, state_q == ST_IDLE)
	`FMPQ_ASSERT_NEXT(a_pop_goes_out, state_q == ST_POP, state_q == ST_OUT)
endmodule
